// ===== hdl/amp_pkg.sv =====
`default_nettype none

package amp_pkg;

  // Widths fixed by the transaction fields and the register map.
  localparam int COUNT_W    = 64;
  localparam int OP_W       = 2;
  localparam int NODE_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int LEN_W      = 5;

  // Longest walk that a compute will build.
  localparam logic [LEN_W-1:0] LEN_LIMIT = 5'd30;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WALK_LENGTH = 1'd1;

  // Control handed from the sequencer to every cell of the chain.
  typedef struct packed {
    logic clear;
    logic unload;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/amp_in_if.sv =====
`default_nettype none

interface amp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [4:0] row;
  logic [4:0] col;
  logic       edge_req;

  modport source (output valid, op, row, col, edge_req, input ready);
  modport sink (input valid, op, row, col, edge_req, output ready);
endinterface

`default_nettype wire

// ===== hdl/amp_out_if.sv =====
`default_nettype none

interface amp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] walk_count;
  logic        saturated;
  logic        done_res;

  modport source (output valid, walk_count, saturated, done_res, input ready);
  modport sink (input valid, walk_count, saturated, done_res, output ready);
endinterface

`default_nettype wire

// ===== hdl/amp_ram.sv =====
`default_nettype none

module amp_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/amp_cell.sv =====
`default_nettype none

module amp_cell import amp_pkg::*; #(
  parameter int MAX_NODES = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cell_ctrl_t                   ctrl,
  // Adjacency column held by this cell.
  input  wire logic                         adj_we,
  input  wire logic [$clog2(MAX_NODES)-1:0] adj_idx,
  input  wire logic                         adj_bit,
  // Token from the left neighbour: one count of the current row.
  input  wire logic                         tok_v_in,
  input  wire logic [$clog2(MAX_NODES)-1:0] tok_k_in,
  input  wire logic [COUNT_W-1:0]           tok_cnt_in,
  input  wire logic                         tok_mark_in,
  output logic                              tok_v_out,
  output logic      [$clog2(MAX_NODES)-1:0] tok_k_out,
  output logic      [COUNT_W-1:0]           tok_cnt_out,
  output logic                              tok_mark_out,
  // Result shift path towards the head of the chain.
  input  wire logic [COUNT_W-1:0]           acc_in,
  input  wire logic                         sat_in,
  output logic      [COUNT_W-1:0]           acc_out,
  output logic                              sat_out
);

  localparam int IW = $clog2(MAX_NODES);

  logic [MAX_NODES-1:0] adj_r;
  logic                 tok_v_r;
  logic [IW-1:0]        tok_k_r;
  logic [COUNT_W-1:0]   tok_cnt_r;
  logic                 tok_mark_r;
  logic [COUNT_W-1:0]   acc_r;
  logic [COUNT_W-1:0]   acc_nxt;
  logic                 sat_r;
  logic                 sat_nxt;
  logic                 hit;
  logic [COUNT_W:0]     sum;

  // A token counts here when the edge from its node to this column exists.
  assign hit = tok_v_in && adj_r[tok_k_in];
  assign sum = {1'b0, acc_r} + {1'b0, tok_cnt_in};

  // Saturating accumulate, clear at row start, shift during unload.
  always_comb begin
    acc_nxt = acc_r;
    sat_nxt = sat_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
      sat_nxt = 1'b0;
    end else if (ctrl.unload) begin
      acc_nxt = acc_in;
      sat_nxt = sat_in;
    end else if (hit) begin
      if (sum[COUNT_W]) begin
        acc_nxt = '1;
        sat_nxt = 1'b1;
      end else begin
        acc_nxt = sum[COUNT_W-1:0];
        sat_nxt = sat_r | tok_mark_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_v_r <= 1'b0;
    end else begin
      tok_v_r <= tok_v_in;
    end
    tok_k_r    <= tok_k_in;
    tok_cnt_r  <= tok_cnt_in;
    tok_mark_r <= tok_mark_in;
    acc_r      <= acc_nxt;
    sat_r      <= sat_nxt;
    if (adj_we) begin
      adj_r[adj_idx] <= adj_bit;
    end
  end

  assign tok_v_out    = tok_v_r;
  assign tok_k_out    = tok_k_r;
  assign tok_cnt_out  = tok_cnt_r;
  assign tok_mark_out = tok_mark_r;
  assign acc_out      = acc_r;
  assign sat_out      = sat_r;

endmodule

`default_nettype wire

// ===== hdl/adjacency_matrix_power_walks.sv =====
// Channel   Direction  Payload                          Handshake
// in_if     sink       op, row, col, edge_req           valid / ready
// out_if    source     walk_count, saturated, done_res  valid / ready
// cfg_*     sink       cfg_idx, cfg_wdata               cfg_we, no wait
//
// A write or unknown op is answered from the idle state; a read waits in
// S_READ for the registered RAM read. A compute for n nodes and walk length
// L runs L passes over the n rows of the cell chain: each row is fed, drained
// through all MAX_NODES cells and unloaded one column per cycle.
// Reset is synchronous; before the first compute every count reads as zero.
// One transaction is worked at a time; a new one is taken once the result
// has left the output register.
`default_nettype none

module adjacency_matrix_power_walks import amp_pkg::*; #(
  parameter int MAX_NODES = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  amp_in_if.sink                     in_if,
  amp_out_if.source                  out_if,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IW    = $clog2(MAX_NODES);
  localparam int NW    = $clog2(MAX_NODES + 1);
  localparam int DW    = $clog2(MAX_NODES + 2);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = MAX_NODES * MAX_NODES;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_ROW, S_FEED, S_DRAIN, S_UNLOAD
  } state_t;

  state_t               state_r;
  logic [CFG_DATA_W-1:0] node_count_r;
  logic [LEN_W-1:0]     walk_length_r;
  logic                 out_valid_r;
  logic [COUNT_W-1:0]   walk_count_r;
  logic                 saturated_r;
  logic                 done_r;
  logic                 computed_r;
  logic                 cur_r;
  logic                 init_r;
  logic                 hit_r;
  logic [NW-1:0]        n_lat_r;
  logic [NW-1:0]        n_comp_r;
  logic [LEN_W-1:0]     passes_r;
  logic [IW-1:0]        i_r;
  logic [IW-1:0]        k_r;
  logic [DW-1:0]        drain_r;
  logic                 feed_v_r;
  logic [IW-1:0]        feed_k_r;

  logic [NW-1:0]        n_eff;
  logic [LEN_W-1:0]     len_eff;
  logic [IW-1:0]        last;
  logic                 in_acc;
  logic                 read_hit;
  logic                 adj_we;
  cell_ctrl_t           ctrl;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic                 wr_en;
  logic [COUNT_W:0]     wdata;
  logic [COUNT_W:0]     rdata0;
  logic [COUNT_W:0]     rdata1;
  logic [COUNT_W:0]     rdata;

  logic                 tok_v    [MAX_NODES+1];
  logic [IW-1:0]        tok_k    [MAX_NODES+1];
  logic [COUNT_W-1:0]   tok_cnt  [MAX_NODES+1];
  logic                 tok_mark [MAX_NODES+1];
  logic [COUNT_W-1:0]   acc_w    [MAX_NODES+1];
  logic                 sat_w    [MAX_NODES+1];

  // Effective node count and walk length, clamped to their ranges.
  always_comb begin
    if (node_count_r < CFG_DATA_W'(2)) begin
      n_eff = NW'(2);
    end else if (32'(node_count_r) > MAX_NODES) begin
      n_eff = NW'(MAX_NODES);
    end else begin
      n_eff = NW'(node_count_r);
    end
    if (walk_length_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (walk_length_r > LEN_LIMIT) begin
      len_eff = LEN_LIMIT;
    end else begin
      len_eff = walk_length_r;
    end
  end

  assign last   = IW'(n_lat_r - NW'(1));
  assign in_acc = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE) && !out_valid_r;

  assign read_hit = computed_r
                 && (32'(in_if.row) < 32'(n_eff)) && (32'(in_if.col) < 32'(n_eff))
                 && (32'(in_if.row) < 32'(n_comp_r)) && (32'(in_if.col) < 32'(n_comp_r));

  assign adj_we = in_acc && (in_if.op == OP_WRITE)
               && (32'(in_if.row) < MAX_NODES) && (32'(in_if.col) < MAX_NODES);

  // Cell control from the sequencer.
  assign ctrl.clear  = (state_r == S_ROW);
  assign ctrl.unload = (state_r == S_UNLOAD);

  // Result store ping-pong: the current bank is read, the other written.
  assign raddr = (state_r == S_FEED) ? {i_r, k_r} : {IW'(in_if.row), IW'(in_if.col)};
  assign waddr = {i_r, k_r};
  assign wr_en = (state_r == S_UNLOAD);
  assign wdata = {sat_w[0], acc_w[0]};
  assign rdata = cur_r ? rdata1 : rdata0;

  amp_ram #(.WIDTH(COUNT_W + 1), .DEPTH(DEPTH)) u_bank0 (
    .clk   (clk),
    .we    (wr_en && cur_r),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata0)
  );

  amp_ram #(.WIDTH(COUNT_W + 1), .DEPTH(DEPTH)) u_bank1 (
    .clk   (clk),
    .we    (wr_en && !cur_r),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata1)
  );

  // Head of the chain: the first pass multiplies the identity row, later
  // passes the stored power row.
  assign tok_v[0]    = feed_v_r;
  assign tok_k[0]    = feed_k_r;
  assign tok_cnt[0]  = init_r ? COUNT_W'(feed_k_r == i_r) : rdata[COUNT_W-1:0];
  assign tok_mark[0] = init_r ? 1'b0 : rdata[COUNT_W];
  assign acc_w[MAX_NODES] = '0;
  assign sat_w[MAX_NODES] = 1'b0;

  // One cell per result column.
  for (genvar j = 0; j < MAX_NODES; j++) begin : g_cell
    amp_cell #(.MAX_NODES(MAX_NODES)) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .adj_we       (adj_we && (IW'(in_if.col) == IW'(j))),
      .adj_idx      (IW'(in_if.row)),
      .adj_bit      (in_if.edge_req),
      .tok_v_in     (tok_v[j]),
      .tok_k_in     (tok_k[j]),
      .tok_cnt_in   (tok_cnt[j]),
      .tok_mark_in  (tok_mark[j]),
      .tok_v_out    (tok_v[j+1]),
      .tok_k_out    (tok_k[j+1]),
      .tok_cnt_out  (tok_cnt[j+1]),
      .tok_mark_out (tok_mark[j+1]),
      .acc_in       (acc_w[j+1]),
      .sat_in       (sat_w[j+1]),
      .acc_out      (acc_w[j]),
      .sat_out      (sat_w[j])
    );
  end

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      node_count_r  <= CFG_DATA_W'(2);
      walk_length_r <= LEN_W'(2);
      out_valid_r   <= 1'b0;
      computed_r    <= 1'b0;
      cur_r         <= 1'b0;
      feed_v_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_NODE_COUNT:  node_count_r  <= cfg_wdata;
          CFG_WALK_LENGTH: walk_length_r <= cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      feed_v_r <= (state_r == S_FEED);
      feed_k_r <= k_r;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_if.op)
              OP_WRITE: begin
                out_valid_r  <= 1'b1;
                walk_count_r <= '0;
                saturated_r  <= 1'b0;
                done_r       <= 1'b1;
              end
              OP_COMPUTE: begin
                n_lat_r  <= n_eff;
                passes_r <= len_eff - LEN_W'(1);
                init_r   <= 1'b1;
                i_r      <= '0;
                state_r  <= S_ROW;
              end
              OP_READ: begin
                hit_r   <= read_hit;
                state_r <= S_READ;
              end
              default: begin
                out_valid_r  <= 1'b1;
                walk_count_r <= '0;
                saturated_r  <= 1'b0;
                done_r       <= 1'b0;
              end
            endcase
          end
        end
        S_READ: begin
          out_valid_r  <= 1'b1;
          walk_count_r <= hit_r ? rdata[COUNT_W-1:0] : '0;
          saturated_r  <= hit_r && rdata[COUNT_W];
          done_r       <= 1'b1;
          state_r      <= S_IDLE;
        end
        S_ROW: begin
          k_r     <= '0;
          state_r <= S_FEED;
        end
        S_FEED: begin
          if (k_r == last) begin
            drain_r <= '0;
            state_r <= S_DRAIN;
          end else begin
            k_r <= k_r + IW'(1);
          end
        end
        S_DRAIN: begin
          // Let the last token pass every cell.
          if (drain_r == DW'(MAX_NODES + 1)) begin
            k_r     <= '0;
            state_r <= S_UNLOAD;
          end else begin
            drain_r <= drain_r + DW'(1);
          end
        end
        S_UNLOAD: begin
          if (k_r == last) begin
            if (i_r == last) begin
              cur_r <= !cur_r;
              i_r   <= '0;
              if (passes_r == '0) begin
                computed_r   <= 1'b1;
                n_comp_r     <= n_lat_r;
                out_valid_r  <= 1'b1;
                walk_count_r <= '0;
                saturated_r  <= 1'b0;
                done_r       <= 1'b1;
                state_r      <= S_IDLE;
              end else begin
                passes_r <= passes_r - LEN_W'(1);
                init_r   <= 1'b0;
                state_r  <= S_ROW;
              end
            end else begin
              i_r     <= i_r + IW'(1);
              state_r <= S_ROW;
            end
          end else begin
            k_r <= k_r + IW'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.walk_count = walk_count_r;
  assign out_if.saturated  = saturated_r;
  assign out_if.done_res   = done_r;

endmodule

`default_nettype wire
